// ===== rtl/core/raf_pkg.sv =====
// Shared constants and helpers for the running average filter.
`default_nettype none

package raf_pkg;

  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned WIN_CFG_W       = 6;
  localparam int unsigned MAX_WINDOW_DEF  = 32;
  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(20);

  // Zero maps to a window of one; anything above the ring depth saturates.
  function automatic int unsigned clamp_window(input logic [WIN_CFG_W-1:0] w,
                                               input int unsigned max_w);
    int unsigned v;
    v = int'(w);
    if (v == 0) begin
      return 1;
    end
    if (v > max_w) begin
      return max_w;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/raf_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module raf_divider
  import raf_pkg::*;
#(
  parameter int unsigned DW = 37,
  parameter int unsigned VW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0]   steps;
  logic            busy;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvsr;
  logic [VW+1:0]   diff;
  logic            borrow;
  logic [VW:0]     shifted;

  assign shifted = {rem, quotient[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr};
  assign borrow  = diff[VW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= CW'(DW);
        rem      <= '0;
        dvsr     <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // Shift the next dividend bit into the remainder, keep it if it fits.
        if (borrow) begin
          rem      <= shifted[VW-1:0];
          quotient <= {quotient[DW-2:0], 1'b0};
        end else begin
          rem      <= diff[VW-1:0];
          quotient <= {quotient[DW-2:0], 1'b1};
        end
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/running_average_filter_core.sv =====
// Top level of the running average filter: sample ring, running sum, sequencer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   input    | in_valid / in_ready     | sample  (32-bit signed)
//   output   | out_valid / out_ready   | average (32-bit signed)
//   config   | cfg_valid / cfg_ready   | window_size (6-bit unsigned)
//
// Each accepted sample passes through the update, start, wait and finish states; the
// wait lasts while the bit-serial divider produces one quotient bit of |sum| / count
// a cycle, and no new sample is taken until the average has been loaded. The result
// sits in an output register; the next sample is taken while it waits, but the final
// load stalls until that register is free.
// Synchronous reset sets the window to 20 and empties the filter at once;
// ring entries are qualified by the fill count, so no clearing pass is needed.
`default_nettype none

module running_average_filter_core
  import raf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      average,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [WIN_CFG_W-1:0]       window_size
);

  localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      window;
  logic [CNT_W-1:0]      fill_count;
  logic [IDX_W-1:0]      write_position;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] sample_ring [MAX_WINDOW];
  logic [CNT_W-1:0]      pos_inc;
  logic                  ring_we;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  sum_neg;
  logic [SUM_W-1:0]      sum_mag;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;
  logic [SUM_W-1:0]      avg_full;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign ring_we   = (state == S_UPDATE);
  assign div_start = (state == S_START);

  // Entries are live only once the ring has been filled since the last clear.
  assign old_sample = (fill_count == window) ? rd_data : '0;
  assign sum_next   = running_sum - SUM_W'(old_sample) + SUM_W'(sample_q);
  assign pos_inc    = CNT_W'(write_position) + CNT_W'(1);

  assign sum_neg  = running_sum[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign avg_full = sum_neg ? SUM_W'(-quotient) : quotient;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      sample_ring[write_position] <= sample_q;
    end
    rd_data <= sample_ring[write_position];
  end

  raf_divider #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window         <= CNT_W'(clamp_window(WINDOW_RESET, MAX_WINDOW));
      fill_count     <= '0;
      write_position <= '0;
      running_sum    <= '0;
      out_valid      <= 1'b0;
    end else begin
      // The finish step reloads the register itself when it is taken.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            window         <= CNT_W'(clamp_window(window_size, MAX_WINDOW));
            fill_count     <= '0;
            write_position <= '0;
            running_sum    <= '0;
          end else if (in_fire) begin
            sample_q <= sample;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          running_sum <= sum_next;
          if (pos_inc >= window) begin
            write_position <= '0;
          end else begin
            write_position <= pos_inc[IDX_W-1:0];
          end
          if (fill_count < window) begin
            fill_count <= fill_count + 1'b1;
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            average   <= avg_full[SAMPLE_W-1:0];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= window)
    else $error("fill count above window");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(write_position) < window)
    else $error("write position outside window");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> fill_count != '0)
    else $error("division started with zero count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready && !cfg_ready)
    else $error("ready while a sample is in work");

endmodule

`default_nettype wire
